### rtl/ppcr_pkg.sv
// Package for the particle/plane collision block.
// Item and configuration types, register codes, divide-by-ten constants
// and saturation. No dependencies.
package ppcr_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [30:0]        radius;
    logic [31:0]        density_in;
    logic               is_fixed;
  } ppcr_in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic [31:0]        density_out;
    logic               collided;
  } ppcr_out_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] plane_offset;
    logic [15:0]        restitution;
  } ppcr_cfg_t;

  // distance-stage result handed to the response stages
  typedef struct packed {
    ppcr_in_t           item;
    logic               hit;
    logic               apply;
    logic signed [38:0] pen;
    logic signed [36:0] vn;
    logic [31:0]        dens_out;
  } ppcr_mid_t;

  typedef enum logic [2:0] {
    REG_NORMAL_X     = 3'd0,
    REG_NORMAL_Y     = 3'd1,
    REG_NORMAL_Z     = 3'd2,
    REG_PLANE_OFFSET = 3'd3,
    REG_RESTITUTION  = 3'd4
  } ppcr_reg_t;

  localparam logic signed [15:0] NORMAL_X_RST    = 16'sd0;
  localparam logic signed [15:0] NORMAL_Y_RST    = 16'sd16384;
  localparam logic signed [15:0] NORMAL_Z_RST    = 16'sd0;
  localparam logic signed [31:0] PLANE_OFF_RST   = 32'sd0;
  localparam logic [15:0]        RESTITUTION_RST = 16'd16384;

  // ceil(2^36 / 10) split at bit 16
  localparam logic [16:0] DIV10_HI = 17'h19999;
  localparam logic [15:0] DIV10_LO = 16'h999A;

  localparam logic [16:0] ONE_Q15 = 17'd32768;

  function automatic logic signed [31:0] sat32(input logic signed [44:0] x);
    if (x > 45'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (x < -45'sd2147483648) begin
      return 32'sh80000000;
    end
    return $signed(x[31:0]);
  endfunction

endpackage

### rtl/ppcr_dot.sv
// Distance stages: dot products, plane test, penetration, v.n, density.
// Three register stages. Uses ppcr_pkg.
module ppcr_dot import ppcr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  ppcr_in_t  item_in,
  input  ppcr_cfg_t cfg,
  output logic      mid_valid,
  output ppcr_mid_t mid
);

  logic signed [31:0] p [3];
  logic signed [31:0] v [3];
  logic signed [15:0] n [3];
  logic [32:0]        y;

  always_comb begin
    p[0] = item_in.pos_x;
    p[1] = item_in.pos_y;
    p[2] = item_in.pos_z;
    v[0] = item_in.vel_x;
    v[1] = item_in.vel_y;
    v[2] = item_in.vel_z;
    n[0] = cfg.normal_x;
    n[1] = cfg.normal_y;
    n[2] = cfg.normal_z;
    y    = 33'(item_in.density_in) + 33'd4;
  end

  // stage 1: products
  logic               s1_valid;
  ppcr_in_t           s1_item;
  logic signed [47:0] s1_pn [3];
  logic signed [47:0] s1_vn [3];
  logic [48:0]        s1_dl;
  logic [49:0]        s1_dh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_item <= item_in;
    for (int i = 0; i < 3; i++) begin
      s1_pn[i] <= p[i] * n[i];
      s1_vn[i] <= v[i] * n[i];
    end
    s1_dl <= 49'(y) * 49'(DIV10_LO);
    s1_dh <= 50'(y) * 50'(DIV10_HI);
  end

  // stage 2: sums, distance, density
  logic signed [49:0] dot;
  logic signed [49:0] vdot;
  logic signed [50:0] d30;
  logic [66:0]        dprod;
  logic [30:0]        dq;

  always_comb begin
    dot   = 50'(s1_pn[0]) + 50'(s1_pn[1]) + 50'(s1_pn[2]);
    vdot  = 50'(s1_vn[0]) + 50'(s1_vn[1]) + 50'(s1_vn[2]);
    d30   = 51'(dot) - (51'(cfg.plane_offset) <<< 14);
    dprod = (67'(s1_dh) << 16) + 67'(s1_dl);
    dq    = dprod[66:36];
  end

  logic               s2_valid;
  ppcr_in_t           s2_item;
  logic signed [50:0] s2_d30;
  logic signed [49:0] s2_vdot;
  logic [31:0]        s2_dens;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  // 0.9 rounded: (9d+5)/10 = d - (d+4)/10
  always_ff @(posedge clk) begin
    s2_item <= s1_item;
    s2_d30  <= d30;
    s2_vdot <= vdot;
    s2_dens <= s1_item.density_in - 32'(dq);
  end

  // stage 3: test and rounding
  logic signed [51:0] rterm;
  logic signed [51:0] diff;
  logic signed [52:0] pen_r;
  logic signed [50:0] vn_r;
  logic               hit;

  always_comb begin
    rterm = $signed(52'({s2_item.radius, 14'd0}));
    hit   = 52'(s2_d30) <= rterm;
    diff  = 52'(s2_d30) - rterm;
    pen_r = 53'(diff) + 53'sd8192;
    vn_r  = 51'(s2_vdot) + 51'sd8192;
  end

  logic      s3_valid;
  ppcr_mid_t s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3.item     <= s2_item;
    s3.hit      <= hit;
    s3.apply    <= hit && !s2_item.is_fixed;
    s3.pen      <= $signed(pen_r[52:14]);
    s3.vn       <= $signed(vn_r[50:14]);
    s3.dens_out <= (hit && !s2_item.is_fixed) ? s2_dens : s2_item.density_in;
  end

  assign mid_valid = s3_valid;
  assign mid       = s3;

endmodule

### rtl/ppcr_resp.sv
// Response stages: position push-out and velocity reflection, saturated.
// Four register stages ending in the result register. Uses ppcr_pkg.
module ppcr_resp import ppcr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      mid_valid,
  input  ppcr_mid_t mid,
  input  ppcr_cfg_t cfg,
  output logic      done,
  output ppcr_out_t result
);

  logic signed [15:0] n [3];
  logic signed [17:0] f;

  always_comb begin
    n[0] = cfg.normal_x;
    n[1] = cfg.normal_y;
    n[2] = cfg.normal_z;
    f    = $signed({1'b0, 17'(cfg.restitution) + ONE_Q15});
  end

  // stage 4: pen*n and vn*(1+e)
  logic               s4_valid;
  ppcr_mid_t          s4_mid;
  logic signed [54:0] s4_pp [3];
  logic signed [54:0] s4_vf;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_mid <= mid;
    for (int i = 0; i < 3; i++) begin
      s4_pp[i] <= mid.pen * n[i];
    end
    s4_vf <= mid.vn * f;
  end

  // stage 5: new position, scale factor s
  logic signed [31:0] p4 [3];
  logic signed [55:0] pp_r [3];
  logic signed [44:0] dp [3];
  logic signed [55:0] vf_r;

  always_comb begin
    p4[0] = s4_mid.item.pos_x;
    p4[1] = s4_mid.item.pos_y;
    p4[2] = s4_mid.item.pos_z;
    for (int i = 0; i < 3; i++) begin
      pp_r[i] = 56'(s4_pp[i]) + 56'sd8192;
      dp[i]   = 45'(p4[i]) - 45'($signed(pp_r[i][55:14]));
    end
    vf_r = 56'(s4_vf) + 56'sd16384;
  end

  logic               s5_valid;
  ppcr_mid_t          s5_mid;
  logic signed [31:0] s5_pos [3];
  logic signed [40:0] s5_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    s5_mid <= s4_mid;
    for (int i = 0; i < 3; i++) begin
      s5_pos[i] <= s4_mid.apply ? sat32(dp[i]) : p4[i];
    end
    s5_s <= $signed(vf_r[55:15]);
  end

  // stage 6: s*n
  logic               s6_valid;
  ppcr_mid_t          s6_mid;
  logic signed [31:0] s6_pos [3];
  logic signed [56:0] s6_sv [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    s6_mid <= s5_mid;
    for (int i = 0; i < 3; i++) begin
      s6_pos[i] <= s5_pos[i];
      s6_sv[i]  <= s5_s * n[i];
    end
  end

  // stage 7: new velocity, result register
  logic signed [31:0] v6 [3];
  logic signed [57:0] sv_r [3];
  logic signed [44:0] dv [3];
  logic signed [31:0] vel [3];

  always_comb begin
    v6[0] = s6_mid.item.vel_x;
    v6[1] = s6_mid.item.vel_y;
    v6[2] = s6_mid.item.vel_z;
    for (int i = 0; i < 3; i++) begin
      sv_r[i] = 58'(s6_sv[i]) + 58'sd8192;
      dv[i]   = 45'(v6[i]) - 45'($signed(sv_r[i][57:14]));
      vel[i]  = s6_mid.apply ? sat32(dv[i]) : v6[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s6_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.new_pos_x   <= s6_pos[0];
    result.new_pos_y   <= s6_pos[1];
    result.new_pos_z   <= s6_pos[2];
    result.new_vel_x   <= vel[0];
    result.new_vel_y   <= vel[1];
    result.new_vel_z   <= vel[2];
    result.density_out <= s6_mid.dens_out;
    result.collided    <= s6_mid.hit;
  end

endmodule

### rtl/particle_plane_collision_response.sv
// Top level of the particle/plane collision block: configuration registers,
// distance pipeline and response pipeline. Uses ppcr_pkg, ppcr_dot, ppcr_resp.
//
// Usage:
//   An item (one particle) is taken at a rising edge with start high and
//   busy low. busy is high only while in reset and in the cycle
//   after it; otherwise a new item may be started in every cycle.
//   The result for an item is on result for one cycle with done high,
//   after seven register stages: three for the dot products and plane test,
//   four for push-out and reflection, the last being the result register.
//   Results come out in start order, one per item, one per cycle at most.
//   The receiver cannot stall, so the pipeline never holds.
//   Plane and restitution registers are written through wr_en, wr_index and
//   wr_data (16-bit registers take the low bits); writes to unused indexes
//   are dropped. Write them only while no item is in flight.
//   Reset (rst, synchronous) empties the pipeline and loads the register
//   defaults: normal (0, 1.0, 0), offset 0, restitution 0.5.
module particle_plane_collision_response import ppcr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  ppcr_in_t    particle,
  output logic        done,
  output ppcr_out_t   result,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data
);

  ppcr_cfg_t cfg;
  logic      accept;
  logic      mid_valid;
  ppcr_mid_t mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normal_x     <= NORMAL_X_RST;
      cfg.normal_y     <= NORMAL_Y_RST;
      cfg.normal_z     <= NORMAL_Z_RST;
      cfg.plane_offset <= PLANE_OFF_RST;
      cfg.restitution  <= RESTITUTION_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_NORMAL_X:     cfg.normal_x     <= $signed(wr_data[15:0]);
        REG_NORMAL_Y:     cfg.normal_y     <= $signed(wr_data[15:0]);
        REG_NORMAL_Z:     cfg.normal_z     <= $signed(wr_data[15:0]);
        REG_PLANE_OFFSET: cfg.plane_offset <= $signed(wr_data);
        REG_RESTITUTION:  cfg.restitution  <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start && !busy;

  ppcr_dot u_dot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .item_in   (particle),
    .cfg       (cfg),
    .mid_valid (mid_valid),
    .mid       (mid)
  );

  ppcr_resp u_resp (
    .clk       (clk),
    .rst       (rst),
    .mid_valid (mid_valid),
    .mid       (mid),
    .cfg       (cfg),
    .done      (done),
    .result    (result)
  );

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##7 done)
    else $error("item not delivered after seven cycles");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 7))
    else $error("result without a started item");

  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    (done && !result.collided) |->
      (result.new_pos_x == $past(particle.pos_x, 7)) &&
      (result.new_vel_z == $past(particle.vel_z, 7)) &&
      (result.density_out == $past(particle.density_in, 7)))
    else $error("item without collision was altered");

  a_density_drop: assert property (@(posedge clk) disable iff (rst)
    done |-> result.density_out <= $past(particle.density_in, 7))
    else $error("density grew");
`endif

endmodule

### sim/particle_plane_collision_response_test.sv
// Testbench for particle_plane_collision_response: directed and random particles
// checked in order against a cycle-free prediction of the plane response.
// Depends on ppcr_pkg and the block's RTL only.
module particle_plane_collision_response_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ppcr_pkg::*;

  class plane_response_model;
    ppcr_cfg_t plane;
    ppcr_out_t response_q[$];
    int        mismatches;

    function new();
      plane.normal_x     = NORMAL_X_RST;
      plane.normal_y     = NORMAL_Y_RST;
      plane.normal_z     = NORMAL_Z_RST;
      plane.plane_offset = PLANE_OFF_RST;
      plane.restitution  = RESTITUTION_RST;
      mismatches         = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_NORMAL_X:     plane.normal_x = data[15:0];
        REG_NORMAL_Y:     plane.normal_y = data[15:0];
        REG_NORMAL_Z:     plane.normal_z = data[15:0];
        REG_PLANE_OFFSET: plane.plane_offset = data;
        REG_RESTITUTION:  plane.restitution = data[15:0];
        default: ;
      endcase
    endfunction

    // shift right, rounding half up
    static function longint round_shift(longint x, int unsigned s);
      return (x + (64'sd1 << (s - 1))) >>> s;
    endfunction

    static function logic [31:0] clamp_q16(longint x);
      if (x > 64'sd2147483647) begin
        return 32'h7FFFFFFF;
      end
      if (x < -64'sd2147483648) begin
        return 32'h80000000;
      end
      return x[31:0];
    endfunction

    function void note_particle(ppcr_in_t p);
      longint    pos[3];
      longint    vel[3];
      longint    nrm[3];
      longint    dot, vdot, sdist, rad, pen, vn, sc;
      logic      hit;
      ppcr_out_t r;
      int        i;
      pos[0] = $signed(p.pos_x);
      pos[1] = $signed(p.pos_y);
      pos[2] = $signed(p.pos_z);
      vel[0] = $signed(p.vel_x);
      vel[1] = $signed(p.vel_y);
      vel[2] = $signed(p.vel_z);
      nrm[0] = $signed(plane.normal_x);
      nrm[1] = $signed(plane.normal_y);
      nrm[2] = $signed(plane.normal_z);
      rad    = longint'(p.radius);
      dot    = 0;
      vdot   = 0;
      for (i = 0; i < 3; i++) begin
        dot  += pos[i] * nrm[i];
        vdot += vel[i] * nrm[i];
      end
      sdist = dot - longint'($signed(plane.plane_offset)) * 16384;
      hit   = (sdist <= rad * 16384);

      r.new_pos_x   = p.pos_x;
      r.new_pos_y   = p.pos_y;
      r.new_pos_z   = p.pos_z;
      r.new_vel_x   = p.vel_x;
      r.new_vel_y   = p.vel_y;
      r.new_vel_z   = p.vel_z;
      r.density_out = p.density_in;
      r.collided    = hit;

      if (hit && !p.is_fixed) begin
        pen = round_shift(sdist - rad * 16384, 14);
        vn  = round_shift(vdot, 14);
        sc  = round_shift(vn * (longint'(ONE_Q15) + longint'(plane.restitution)), 15);
        r.new_pos_x   = clamp_q16(pos[0] - round_shift(pen * nrm[0], 14));
        r.new_pos_y   = clamp_q16(pos[1] - round_shift(pen * nrm[1], 14));
        r.new_pos_z   = clamp_q16(pos[2] - round_shift(pen * nrm[2], 14));
        r.new_vel_x   = clamp_q16(vel[0] - round_shift(sc * nrm[0], 14));
        r.new_vel_y   = clamp_q16(vel[1] - round_shift(sc * nrm[1], 14));
        r.new_vel_z   = clamp_q16(vel[2] - round_shift(sc * nrm[2], 14));
        r.density_out = (longint'(p.density_in) * 9 + 5) / 10;
      end
      response_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_response(ppcr_out_t got);
      ppcr_out_t want;
      if (response_q.size() == 0) begin
        $error("response with no particle pending");
        mismatches++;
      end else begin
        want = response_q.pop_front();
        compare_field("new_pos_x", want.new_pos_x, got.new_pos_x);
        compare_field("new_pos_y", want.new_pos_y, got.new_pos_y);
        compare_field("new_pos_z", want.new_pos_z, got.new_pos_z);
        compare_field("new_vel_x", want.new_vel_x, got.new_vel_x);
        compare_field("new_vel_y", want.new_vel_y, got.new_vel_y);
        compare_field("new_vel_z", want.new_vel_z, got.new_vel_z);
        compare_field("density_out", want.density_out, got.density_out);
        compare_field("collided", 32'(want.collided), 32'(got.collided));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  ppcr_in_t    particle;
  logic        done;
  ppcr_out_t   result;
  logic        wr_en;
  logic [2:0]  wr_index;
  logic [31:0] wr_data;
  bit          idling_on;

  plane_response_model sb = new();

  particle_plane_collision_response i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .particle (particle),
    .done     (done),
    .result   (result),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_response(result);
    end
  end

  function automatic ppcr_in_t build_particle(logic [31:0] px, py, pz, vx, vy, vz,
                                              logic [30:0] rad, logic [31:0] dens,
                                              logic fixed);
    ppcr_in_t it;
    it.pos_x      = px;
    it.pos_y      = py;
    it.pos_z      = pz;
    it.vel_x      = vx;
    it.vel_y      = vy;
    it.vel_z      = vz;
    it.radius     = rad;
    it.density_in = dens;
    it.is_fixed   = fixed;
    return it;
  endfunction

  function automatic ppcr_in_t random_particle();
    ppcr_in_t it;
    bit       near;
    int       vshift;
    near   = $urandom_range(0, 1);
    vshift = near ? $urandom_range(0, 20) : 0;
    it.pos_x      = near ? int'($urandom()) >>> 11 : $urandom();
    it.pos_y      = near ? int'($urandom()) >>> 11 : $urandom();
    it.pos_z      = near ? int'($urandom()) >>> 11 : $urandom();
    it.vel_x      = int'($urandom()) >>> vshift;
    it.vel_y      = int'($urandom()) >>> vshift;
    it.vel_z      = int'($urandom()) >>> vshift;
    it.radius     = near ? 31'($urandom_range(0, 1 << 20)) : 31'($urandom());
    it.density_in = ($urandom_range(0, 15) == 0) ? 32'hFFFFFFFF : $urandom();
    it.is_fixed   = ($urandom_range(0, 3) == 0);
    return it;
  endfunction

  function automatic logic [15:0] random_normal();
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  task automatic send_particle(ppcr_in_t it);
    start    <= 1'b1;
    particle <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_particle(it);
  endtask

  task automatic maybe_idle();
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start    <= 1'b0;
      particle <= random_particle();
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.response_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // upper bits of the 16-bit registers carry junk
  task automatic configure(input logic [15:0] nx, ny, nz, input logic [31:0] off,
                           input logic [15:0] e);
    int k;
    drain();
    write_reg(REG_NORMAL_X, {16'($urandom()), nx});
    write_reg(REG_NORMAL_Y, {16'($urandom()), ny});
    write_reg(REG_NORMAL_Z, {16'($urandom()), nz});
    write_reg(REG_PLANE_OFFSET, off);
    write_reg(REG_RESTITUTION, {16'($urandom()), e});
    for (k = int'(REG_RESTITUTION) + 1; k < (1 << $bits(ppcr_reg_t)); k++) begin
      write_reg(k[2:0], $urandom());
    end
    wr_en <= 1'b0;
  endtask

  task automatic configure_random();
    logic [31:0] off;
    logic [15:0] e;
    off = $urandom();
    if ($urandom_range(0, 1) == 1) begin
      off = int'(off) >>> 11;
    end
    e = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(32769, 65535))
                                    : 16'($urandom_range(0, 32768));
    configure(random_normal(), random_normal(), random_normal(), off, e);
  endtask

  // boundary, fixed, field extremes and saturation
  task automatic send_directed();
    send_particle(build_particle(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_particle(build_particle(32'h1234, 32'h10000, 32'hFFFF0000, 32'h1234,
                                 32'hFFFE0000, 32'h5678, 31'h10000, 32'h000A0000, 1'b0));
    send_particle(build_particle(32'h1234, 32'h10001, 32'hFFFF0000, 32'h1234,
                                 32'hFFFE0000, 32'h5678, 31'h10000, 32'h000A0000, 1'b0));
    send_particle(build_particle(32'h40000, 32'hFFFD0000, 32'h1, 32'h30000,
                                 32'hFFFF8000, 32'h7, 31'h10000, 32'h00123456, 1'b1));
    send_particle(build_particle(32'h0, 32'h7FFF0000, 32'h0, 32'h10000, 32'h10000,
                                 32'h10000, 31'h0, 32'h00050000, 1'b1));
    send_particle(build_particle(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                                 32'h80000000, 32'h80000000, 31'h7FFFFFFF,
                                 32'hFFFFFFFF, 1'b0));
    send_particle(build_particle(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                                 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h0, 32'h0, 1'b0));
    send_particle(build_particle(32'h0, 32'h80000000, 32'h0, 32'h0, 32'h80000000, 32'h0,
                                 31'h0, 32'h1, 1'b0));
    send_particle(build_particle(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h1, 32'h7FFFFFFF,
                                 32'h7FFFFFFF, 32'h80000000, 31'h1, 32'h9, 1'b0));
  endtask

  task automatic send_random(int count);
    repeat (count) begin
      maybe_idle();
      send_particle(random_particle());
    end
  endtask

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    particle  <= '0;
    wr_en     <= 1'b0;
    wr_index  <= '0;
    wr_data   <= '0;
    idling_on = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset plane: y up through the origin, restitution 0.5
    send_directed();
    send_random(55);

    configure(16'sd16384, 16'sd0, 16'sd0, 32'h7FFFFFFF, 16'd0);
    send_random(55);

    configure(16'sd0, 16'sd0, -16'sd16384, 32'h80000000, 16'd32768);
    send_random(25);
    drain();
    send_random(30);

    // non-unit normal, restitution above one
    configure(-16'sd16384, -16'sd16384, -16'sd16384, 32'h0, 16'hFFFF);
    send_directed();
    send_random(55);

    repeat (5) begin
      configure_random();
      send_random(55);
    end

    idling_on = 1'b0;
    configure_random();
    send_random(80);

    drain();
    repeat (12) @(posedge clk);
    if (sb.mismatches == 0 && sb.response_q.size() == 0) begin
      $display("particle_plane_collision_response_test: PASS");
    end else begin
      $display("particle_plane_collision_response_test: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("particle_plane_collision_response_test: FAIL");
    $finish;
  end

endmodule
